// ----- src/mwpm_pkg.sv -----
`default_nettype none

package mwpm_pkg;

	localparam int WINDOW_BITS   = 24;
	localparam int TABLE_ENTRIES = 16;

	localparam int ACT_W   = 2;
	localparam int IDX_W   = 4;
	localparam int PAT_W   = 24;
	localparam int ID_W    = 16;
	localparam int CNT_W   = 21;
	localparam int POS_W   = 20;

	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 40;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] POS_MAX = CNT_W'({POS_W{1'b1}});

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD  = 2'd0,
		ACT_BIT   = 2'd1,
		ACT_START = 2'd2
	} act_t;

	typedef logic [WINDOW_BITS-1:0] win_t;

	// table write into one cell
	typedef struct packed {
		logic          we;
		logic          used;
		win_t          value;
		win_t          mask;
		logic [ID_W-1:0] id;
	} load_t;

	// ordered result selection travelling down the chain
	typedef struct packed {
		logic          taken;
		logic [ID_W-1:0] id;
		logic          last;
	} link_t;

	function automatic win_t fit_pattern(input logic [PAT_W-1:0] p);
		logic [63:0] e;
		e = 64'(p);
		return e[WINDOW_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- src/mwpm_seq.sv -----
`default_nettype none

module mwpm_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        bit_en,
	input  wire logic                        start_en,
	input  wire logic                        seq_bit,
	output mwpm_pkg::win_t                   window_next,
	output logic                             full_next,
	output logic [mwpm_pkg::POS_W-1:0]       position
);

	mwpm_pkg::win_t                  window_q;
	logic [mwpm_pkg::CNT_W-1:0]      cnt_q;
	logic [mwpm_pkg::CNT_W-1:0]      cnt_next;
	logic [mwpm_pkg::CNT_W-1:0]      diff;
	logic [mwpm_pkg::POS_W-1:0]      pos_next;
	logic [mwpm_pkg::POS_W-1:0]      pos_q;

	always_comb begin
		window_next = {seq_bit, window_q[mwpm_pkg::WINDOW_BITS-1:1]};
		cnt_next    = (cnt_q == mwpm_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;
		full_next   = cnt_next >= mwpm_pkg::CNT_W'(mwpm_pkg::WINDOW_BITS);
		diff        = cnt_next - mwpm_pkg::CNT_W'(mwpm_pkg::WINDOW_BITS);
		pos_next    = (diff > mwpm_pkg::POS_MAX) ? mwpm_pkg::POS_MAX[mwpm_pkg::POS_W-1:0]
		                                         : diff[mwpm_pkg::POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			cnt_q    <= '0;
		end else if (start_en) begin
			window_q <= '0;
			cnt_q    <= '0;
		end else if (bit_en) begin
			window_q <= window_next;
			cnt_q    <= cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (bit_en) begin
			pos_q <= pos_next;
		end
	end

	assign position = pos_q;

endmodule

`default_nettype wire

// ----- src/mwpm_cell.sv -----
`default_nettype none

module mwpm_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mwpm_pkg::load_t load,
	input  wire logic            cmp_en,
	input  wire mwpm_pkg::win_t  window,
	input  wire logic            pop,
	input  wire mwpm_pkg::link_t fwd_in,
	output mwpm_pkg::link_t      fwd_out,
	input  wire logic            later_in,
	output logic                 later_out
);

	mwpm_pkg::win_t                 value_q;
	mwpm_pkg::win_t                 mask_q;
	logic [mwpm_pkg::ID_W-1:0]      id_q;
	logic                           used_q;
	logic                           hit_q;
	logic                           sel;

	always_ff @(posedge clk) begin
		if (load.we) begin
			value_q <= load.value & load.mask;
			mask_q  <= load.mask;
			id_q    <= load.id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			if (load.we) begin
				used_q <= load.used;
			end
			if (cmp_en) begin
				hit_q <= used_q && ((window & mask_q) == value_q);
			end else if (pop && sel) begin
				hit_q <= 1'b0;
			end
		end
	end

	// first pending hit in table order owns the output
	assign sel = hit_q && !fwd_in.taken;

	always_comb begin
		fwd_out.taken = fwd_in.taken | hit_q;
		fwd_out.id    = fwd_in.id | (sel ? id_q : '0);
		fwd_out.last  = fwd_in.last | (sel && !later_in);
		later_out     = later_in | hit_q;
	end

endmodule

`default_nettype wire

// ----- src/masked_window_pattern_matcher_unit.sv -----
// latency: a sequence bit transfer gives its first result on the next cycle
// throughput: one item per cycle; a bit with k matches holds off input until all k
// are taken, one result per cycle (m_tready high) from the cell chain in table order
// reset: arst_n clears window, bit count, entry used flags and pending hits;
// entry contents are undefined until loaded
`default_nettype none

module masked_window_pattern_matcher_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// entry_index, entry_valid, pattern_value, pattern_mask, pattern_id, seq_bit
	input  wire logic [mwpm_pkg::S_DATA_W-1:0]  s_tdata,
	// action
	input  wire logic [mwpm_pkg::ACT_W-1:0]     s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// position, match_id
	output logic [mwpm_pkg::M_DATA_W-1:0]       m_tdata,
	output logic                                m_tlast
);

	localparam int N = mwpm_pkg::TABLE_ENTRIES;

	mwpm_pkg::act_t                 action;
	logic                           accept;
	logic                           bit_en;
	logic                           start_en;
	logic                           load_en;
	logic                           cmp_en;
	logic                           pop;
	mwpm_pkg::win_t                 window_next;
	logic                           full_next;
	logic [mwpm_pkg::POS_W-1:0]     position;
	logic [mwpm_pkg::IDX_W-1:0]     entry_index;
	mwpm_pkg::load_t                load_base;
	mwpm_pkg::load_t                load [N];
	mwpm_pkg::link_t                fwd [N+1];
	logic                           later [N+1];

	assign action      = mwpm_pkg::act_t'(s_tuser);
	assign s_tready    = !m_tvalid;
	assign accept      = s_tvalid && s_tready;
	assign bit_en      = accept && (action == mwpm_pkg::ACT_BIT);
	assign start_en    = accept && (action == mwpm_pkg::ACT_START);
	assign load_en     = accept && (action == mwpm_pkg::ACT_LOAD);
	assign cmp_en      = bit_en && full_next;
	assign pop         = m_tvalid && m_tready;
	assign entry_index = s_tdata[3:0];

	always_comb begin
		load_base.we    = 1'b0;
		load_base.used  = s_tdata[4];
		load_base.value = mwpm_pkg::fit_pattern(s_tdata[28:5]);
		load_base.mask  = mwpm_pkg::fit_pattern(s_tdata[52:29]);
		load_base.id    = s_tdata[68:53];
	end

	mwpm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.bit_en      (bit_en),
		.start_en    (start_en),
		.seq_bit     (s_tdata[69]),
		.window_next (window_next),
		.full_next   (full_next),
		.position    (position)
	);

	assign fwd[0]   = '0;
	assign later[N] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		always_comb begin
			load[i]    = load_base;
			load[i].we = load_en && (32'(entry_index) == 32'(i));
		end

		mwpm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (load[i]),
			.cmp_en    (cmp_en),
			.window    (window_next),
			.pop       (pop),
			.fwd_in    (fwd[i]),
			.fwd_out   (fwd[i+1]),
			.later_in  (later[i+1]),
			.later_out (later[i])
		);
	end

	assign m_tvalid = fwd[N].taken;
	assign m_tlast  = fwd[N].last;
	assign m_tdata  = {(mwpm_pkg::M_DATA_W - mwpm_pkg::POS_W - mwpm_pkg::ID_W)'(0),
	                   fwd[N].id, position};

endmodule

`default_nettype wire

// ----- src/mwpm_checker.sv -----
`default_nettype none

module mwpm_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	input  wire logic [mwpm_pkg::ACT_W-1:0]     s_tuser,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic [mwpm_pkg::M_DATA_W-1:0]  m_tdata,
	input  wire logic                           m_tlast
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input taken while results pending");

	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid &&
		(m_tdata[mwpm_pkg::POS_W-1:0] == $past(m_tdata[mwpm_pkg::POS_W-1:0])))
		else $error("burst ended early or position moved");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("result after last");

	a_non_bit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != mwpm_pkg::ACT_W'(mwpm_pkg::ACT_BIT)) |=> !m_tvalid)
		else $error("result from a non-sequence transfer");

endmodule

bind masked_window_pattern_matcher_unit mwpm_checker u_mwpm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
